// File: src/partition_index_translator_unit_macros.svh
// Assertion helpers for the partition index translator checker
`ifndef PARTITION_INDEX_TRANSLATOR_UNIT_MACROS_SVH
`define PARTITION_INDEX_TRANSLATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PIT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pit: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pit: assertion failed");

`endif

// File: src/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants of the partition index translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pit_pkg;

    localparam int DEF_MAX_NODES    = 256;
    localparam int DEF_MAX_FAMILIES = 32;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [5:0]  NO_MARK  = 6'd63;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_IO    = 2'd1;
    localparam logic [1:0] ST_BAD_TABLE = 2'd2;

    typedef enum logic [2:0] {
        OP_REG_IO = 3'd0,
        OP_ADD    = 3'd1,
        OP_FWD    = 3'd2,
        OP_REV    = 3'd3,
        OP_SITES  = 3'd4,
        OP_RANK   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_REG,
        CMD_ADD,
        CMD_FWD,
        CMD_REV,
        CMD_SITES,
        CMD_RANK
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        node_ok;
        logic        io_ok;
        logic        rank_ok;
        logic [7:0]  node;
        logic [7:0]  io_node;
        logic [4:0]  rank;
        logic [23:0] site_count;
        logic [31:0] index;
    } item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DEC,
        S_ASCAN,
        S_FAM,
        S_FAMD,
        S_RSCAN,
        S_OUT
    } state_t;

endpackage

// File: src/pit_front.sv
// ----------------------------------------------------------------------------
// pit_front
// Accepts input words, decodes the operation and range-checks the fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pit_front #(
    parameter int MAX_NODES    = pit_pkg::DEF_MAX_NODES,
    parameter int MAX_FAMILIES = pit_pkg::DEF_MAX_FAMILIES
) (
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [2:0]     s_op,
    input  logic [7:0]     s_node,
    input  logic [7:0]     s_io_node,
    input  logic [4:0]     s_rank,
    input  logic [23:0]    s_site_count,
    input  logic [31:0]    s_index,
    input  logic           q_full,
    input  logic           clearing,
    output logic           push,
    output pit_pkg::item_t push_item
);
    import pit_pkg::*;

    cmd_t cmd;

    always_comb begin
        case (s_op)
            OP_REG_IO: cmd = CMD_REG;
            OP_ADD:    cmd = CMD_ADD;
            OP_FWD:    cmd = CMD_FWD;
            OP_REV:    cmd = CMD_REV;
            OP_SITES:  cmd = CMD_SITES;
            OP_RANK:   cmd = CMD_RANK;
            default:   cmd = CMD_NOP;
        endcase
    end

    // hold off while the tables are being cleared
    assign s_ready = !q_full && !clearing;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_item.cmd        = cmd;
        push_item.node_ok    = ({24'd0, s_node} < 32'(MAX_NODES));
        push_item.io_ok      = ({24'd0, s_io_node} < 32'(MAX_NODES));
        push_item.rank_ok    = ({27'd0, s_rank} < 32'(MAX_FAMILIES));
        push_item.node       = s_node;
        push_item.io_node    = s_io_node;
        push_item.rank       = s_rank;
        push_item.site_count = s_site_count;
        push_item.index      = s_index;
    end

endmodule

// File: src/pit_queue.sv
// ----------------------------------------------------------------------------
// pit_queue
// Short queue of decoded words between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pit_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pit_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output pit_pkg::item_t head
);
    import pit_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           buf_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign head    = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/pit_back.sv
// ----------------------------------------------------------------------------
// pit_back
// Sequencer that owns the node and family tables and carries out each word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pit_back #(
    parameter int MAX_NODES    = pit_pkg::DEF_MAX_NODES,
    parameter int MAX_FAMILIES = pit_pkg::DEF_MAX_FAMILIES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           q_valid,
    input  pit_pkg::item_t head,
    output logic           pop,
    output logic           clearing,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic [7:0]     m_node_out,
    output logic [31:0]    m_value
);
    import pit_pkg::*;

    localparam int NAW   = $clog2(MAX_NODES);
    localparam int FAW   = (MAX_FAMILIES > 1) ? $clog2(MAX_FAMILIES) : 1;
    localparam int SW    = NAW + 1;
    localparam int CLR_N = (MAX_NODES > MAX_FAMILIES) ? MAX_NODES : MAX_FAMILIES;
    localparam int CW    = $clog2(CLR_N + 1);

    // tables
    logic [5:0]  rank_mem  [MAX_NODES];
    logic [5:0]  fam_mem   [MAX_NODES];
    logic [31:0] off_mem   [MAX_NODES];
    logic [31:0] tot_mem   [MAX_FAMILIES];
    logic [8:0]  size_mem  [MAX_FAMILIES];
    logic [7:0]  fnode_mem [MAX_FAMILIES];
    logic [23:0] fsite_mem [MAX_FAMILIES];

    logic [5:0]  rank_rd, fam_rd;
    logic [31:0] off_rd, tot_rd;
    logic [8:0]  size_rd;
    logic [7:0]  fnode_rd;
    logic [23:0] fsite_rd;

    state_t         state_reg, state_next;
    item_t          item_reg;
    logic [5:0]     k_reg;
    logic [CW-1:0]  clr_reg;
    logic [SW-1:0]  scan_reg, scan_next;
    logic           pend_reg;
    logic [NAW-1:0] pend_idx_reg;
    logic [NAW-1:0] found_reg, found_next;
    logic [31:0]    found_off_reg, found_off_next;
    logic           fake_reg;
    logic [1:0]     res_status_reg, res_status_next;
    logic [7:0]     res_node_reg, res_node_next;
    logic [31:0]    res_value_reg, res_value_next;

    // memory controls
    logic [NAW-1:0] node_raddr, node_waddr, rank_waddr;
    logic [FAW-1:0] fam_addr;
    logic           rank_we, node_we, famt_we, first_we;
    logic [5:0]     rank_wdata, fam_wdata;
    logic [31:0]    off_wdata, tot_wdata;
    logic [8:0]     size_wdata;

    logic [NAW-1:0] node_idx;
    logic           issue, rank_bad, scan_hit;

    assign node_idx = NAW'(item_reg.node);
    assign issue    = (scan_reg < SW'(MAX_NODES));
    // an I/O node past the table is never registered
    assign rank_bad = (rank_rd == NO_MARK) || !item_reg.io_ok;
    assign scan_hit = pend_reg && (fam_rd == k_reg);

    assign clearing   = (state_reg == S_CLEAR);
    assign pop        = (state_reg == S_IDLE) && q_valid;
    assign m_valid    = (state_reg == S_OUT);
    assign m_status   = res_status_reg;
    assign m_node_out = res_node_reg;
    assign m_value    = res_value_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == CW'(CLR_N - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (q_valid) state_next = S_LOOK;
            end
            S_LOOK: state_next = S_DEC;
            S_DEC: begin
                case (item_reg.cmd)
                    CMD_ADD: begin
                        if (rank_bad || !item_reg.node_ok || fam_rd != NO_MARK) begin
                            state_next = S_OUT;
                        end else if (SW'(item_reg.node) + SW'(1) < SW'(MAX_NODES)) begin
                            state_next = S_ASCAN;
                        end else begin
                            state_next = S_FAM;
                        end
                    end
                    CMD_REV: begin
                        if (!fake_reg || rank_bad) state_next = S_OUT;
                        else state_next = S_FAM;
                    end
                    CMD_SITES: begin
                        if (rank_bad) state_next = S_OUT;
                        else state_next = S_FAM;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_ASCAN: begin
                if (scan_hit) state_next = S_OUT;
                else if (!issue && !pend_reg) state_next = S_FAM;
            end
            S_FAM: state_next = S_FAMD;
            S_FAMD: begin
                if (item_reg.cmd == CMD_REV && size_rd != '0
                        && !(size_rd >= 9'd2 && fsite_rd == '0)) begin
                    state_next = S_RSCAN;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_RSCAN: begin
                if (!issue && !pend_reg) state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // datapath and table controls
    always_comb begin
        rank_we         = 1'b0;
        node_we         = 1'b0;
        famt_we         = 1'b0;
        first_we        = 1'b0;
        rank_waddr      = NAW'(item_reg.io_node);
        rank_wdata      = {1'b0, item_reg.rank};
        node_waddr      = node_idx;
        fam_wdata       = k_reg;
        off_wdata       = tot_rd;
        fam_addr        = FAW'(k_reg);
        tot_wdata       = tot_rd + {8'd0, item_reg.site_count};
        size_wdata      = size_rd + 9'd1;
        node_raddr      = node_idx;
        scan_next       = scan_reg;
        found_next      = found_reg;
        found_off_next  = found_off_reg;
        res_status_next = ST_OK;
        res_node_next   = '0;
        res_value_next  = '0;

        case (state_reg)
            S_CLEAR: begin
                rank_waddr = NAW'(clr_reg);
                node_waddr = NAW'(clr_reg);
                fam_addr   = FAW'(clr_reg);
                rank_wdata = NO_MARK;
                fam_wdata  = NO_MARK;
                off_wdata  = '0;
                tot_wdata  = '0;
                size_wdata = '0;
                rank_we    = (clr_reg < CW'(MAX_NODES));
                node_we    = (clr_reg < CW'(MAX_NODES));
                famt_we    = (clr_reg < CW'(MAX_FAMILIES));
            end
            S_DEC: begin
                scan_next = SW'(item_reg.node) + SW'(1);
                case (item_reg.cmd)
                    CMD_REG: begin
                        if (item_reg.io_ok && item_reg.rank_ok) begin
                            rank_we        = 1'b1;
                            res_value_next = {27'd0, item_reg.rank};
                        end else begin
                            res_status_next = ST_BAD_TABLE;
                        end
                    end
                    CMD_ADD: begin
                        if (rank_bad) res_status_next = ST_NOT_IO;
                        else res_status_next = ST_BAD_TABLE;
                    end
                    CMD_FWD: begin
                        res_node_next  = item_reg.node;
                        res_value_next = (fake_reg && item_reg.node_ok)
                                       ? off_rd + item_reg.index : item_reg.index;
                    end
                    CMD_REV: begin
                        if (!fake_reg) begin
                            res_node_next  = item_reg.io_node;
                            res_value_next = item_reg.index;
                        end else begin
                            res_status_next = ST_NOT_IO;
                        end
                    end
                    CMD_SITES: res_status_next = ST_NOT_IO;
                    CMD_RANK: begin
                        if (!fake_reg) begin
                            res_value_next = {24'd0, item_reg.io_node};
                        end else if (rank_bad) begin
                            res_status_next = ST_NOT_IO;
                            res_value_next  = ALL_ONES;
                        end else begin
                            res_value_next = {26'd0, rank_rd};
                        end
                    end
                    default: ;
                endcase
            end
            S_ASCAN: begin
                node_raddr      = scan_reg[NAW-1:0];
                res_status_next = ST_BAD_TABLE;
                if (issue) scan_next = scan_reg + SW'(1);
            end
            S_FAMD: begin
                scan_next      = '0;
                found_next     = NAW'(fnode_rd);
                found_off_next = '0;
                case (item_reg.cmd)
                    CMD_SITES: res_value_next = tot_rd;
                    CMD_ADD: begin
                        node_we        = 1'b1;
                        famt_we        = 1'b1;
                        first_we       = (size_rd == '0);
                        res_node_next  = item_reg.node;
                        res_value_next = tot_rd;
                    end
                    default: res_status_next = ST_BAD_TABLE;
                endcase
            end
            S_RSCAN: begin
                node_raddr = scan_reg[NAW-1:0];
                if (issue) scan_next = scan_reg + SW'(1);
                // keep the last member whose offset does not pass the index
                if (scan_hit && off_rd <= item_reg.index) begin
                    found_next     = pend_idx_reg;
                    found_off_next = off_rd;
                end
                res_node_next  = 8'(found_reg);
                res_value_next = item_reg.index - found_off_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            fake_reg  <= 1'b1;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + CW'(1);
            if (cfg_wr_en) fake_reg <= cfg_wr_data;
            pend_reg <= (state_reg == S_ASCAN || state_reg == S_RSCAN) && issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) item_reg <= head;
        if (state_reg == S_DEC) k_reg <= rank_rd;
        scan_reg      <= scan_next;
        pend_idx_reg  <= scan_reg[NAW-1:0];
        found_reg     <= found_next;
        found_off_reg <= found_off_next;
        if (state_next == S_OUT && state_reg != S_OUT) begin
            res_status_reg <= res_status_next;
            res_node_reg   <= res_node_next;
            res_value_reg  <= res_value_next;
        end
    end

    // node tables
    always_ff @(posedge aclk) begin
        if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
        rank_rd <= rank_mem[NAW'(item_reg.io_node)];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            fam_mem[node_waddr] <= fam_wdata;
            off_mem[node_waddr] <= off_wdata;
        end
        fam_rd <= fam_mem[node_raddr];
        off_rd <= off_mem[node_raddr];
    end

    // family tables
    always_ff @(posedge aclk) begin
        if (famt_we) begin
            tot_mem[fam_addr]  <= tot_wdata;
            size_mem[fam_addr] <= size_wdata;
        end
        if (first_we) begin
            fnode_mem[fam_addr] <= item_reg.node;
            fsite_mem[fam_addr] <= item_reg.site_count;
        end
        tot_rd   <= tot_mem[fam_addr];
        size_rd  <= size_mem[fam_addr];
        fnode_rd <= fnode_mem[fam_addr];
        fsite_rd <= fsite_mem[fam_addr];
    end

endmodule

// File: src/partition_index_translator_unit.sv
// ----------------------------------------------------------------------------
// partition_index_translator_unit
// Maps node-local site indices to per-family combined indices and back.
//
//  channel   | direction | fields
//  s_        | in        | op, node, io_node, rank, site_count, index
//  m_        | out       | status, node_out, value
//  cfg_wr_   | in        | data = fake layout enable
//
// An add scans the node table above the new node. A reverse lookup in the
// fake layout on a valid family scans the whole node table.
// After reset a clearing pass over max(MAX_NODES, MAX_FAMILIES) table
// entries runs with s_ready low. A stalled result holds the back part;
// the front queue still takes up to four words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module partition_index_translator_unit #(
    parameter int MAX_NODES    = pit_pkg::DEF_MAX_NODES,
    parameter int MAX_FAMILIES = pit_pkg::DEF_MAX_FAMILIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [7:0]  s_node,
    input  logic [7:0]  s_io_node,
    input  logic [4:0]  s_rank,
    input  logic [23:0] s_site_count,
    input  logic [31:0] s_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_node_out,
    output logic [31:0] m_value
);
    import pit_pkg::*;

    item_t push_item, head;
    logic  push, q_full, pop, q_valid, clearing;

    pit_front #(
        .MAX_NODES    (MAX_NODES),
        .MAX_FAMILIES (MAX_FAMILIES)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_node       (s_node),
        .s_io_node    (s_io_node),
        .s_rank       (s_rank),
        .s_site_count (s_site_count),
        .s_index      (s_index),
        .q_full       (q_full),
        .clearing     (clearing),
        .push         (push),
        .push_item    (push_item)
    );

    pit_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    pit_back #(
        .MAX_NODES    (MAX_NODES),
        .MAX_FAMILIES (MAX_FAMILIES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .head        (head),
        .pop         (pop),
        .clearing    (clearing),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_node_out  (m_node_out),
        .m_value     (m_value)
    );

endmodule

// File: src/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks of the partition index translator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "partition_index_translator_unit_macros.svh"

module pit_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [7:0]  m_node_out,
    input logic [31:0] m_value
);
    import pit_pkg::*;

    // a stalled result word holds
    `PIT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_status))
    `PIT_ASSERT_IMPL(a_status_code, m_valid, m_status != 2'd3)
    `PIT_ASSERT_IMPL(a_err_node, m_valid && m_status != ST_OK, m_node_out == 8'd0)
    `PIT_ASSERT_IMPL(a_err_value, m_valid && m_status != ST_OK, m_value == 32'd0 || (m_value == ALL_ONES && m_status == ST_NOT_IO))

endmodule

bind partition_index_translator_unit pit_checker u_pit_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_node_out (m_node_out),
    .m_value    (m_value)
);

// File: bench/partition_index_translator_unit_tb.sv
// ----------------------------------------------------------------------------
// partition_index_translator_unit_tb
// Self-checking bench for the partition index translator. A behavioural
// copy of the family tables predicts every result word as the stimulus is
// queued. A clocked driver and monitor move the words under random idling
// and back-pressure, across phases with the fake layout switched on and off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module partition_index_translator_unit_tb;
    import pit_pkg::*;

    localparam int NODES    = DEF_MAX_NODES;
    localparam int FAMILIES = DEF_MAX_FAMILIES;
    localparam int SETTLE   = 2 * NODES + 50;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  node;
        logic [7:0]  io_node;
        logic [4:0]  rank;
        logic [23:0] site_count;
        logic [31:0] index;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  node_out;
        logic [31:0] value;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [7:0]  s_node = '0;
    logic [7:0]  s_io_node = '0;
    logic [4:0]  s_rank = '0;
    logic [23:0] s_site_count = '0;
    logic [31:0] s_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_node_out;
    logic [31:0] m_value;

    partition_index_translator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_node(s_node),
        .s_io_node(s_io_node), .s_rank(s_rank), .s_site_count(s_site_count),
        .s_index(s_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_node_out(m_node_out), .m_value(m_value)
    );

    // shadow of the family tables
    logic        fake_on;
    logic [5:0]  io_rank [NODES];
    logic [5:0]  node_family [NODES];
    logic [31:0] node_base [NODES];
    logic [31:0] fam_total [FAMILIES];
    int          fam_members [FAMILIES];
    logic [7:0]  fam_first_node [FAMILIES];
    logic [23:0] fam_first_sites [FAMILIES];

    request_t word_q[$];
    answer_t  answer_q[$];
    int       mismatches = 0;
    int       send_idle = 0;
    int       recv_stall = 0;
    logic     s_took = 1'b0;
    request_t drv_word;
    answer_t  want;

    // generator state: most random adds go out in ascending node order
    int       next_node;
    logic [7:0] io_pool[$];

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("partition_index_translator_unit test failed");
        $finish;
    end

    function automatic answer_t translate(request_t r);
        answer_t    o;
        logic [5:0] k;
        int         found;
        logic       clash;
        o = '{ST_OK, 8'd0, 32'd0};
        k = io_rank[r.io_node];
        case (r.op)
            OP_REG_IO: begin
                io_rank[r.io_node] = {1'b0, r.rank};
                o.value = 32'(r.rank);
            end
            OP_ADD: begin
                if (k == NO_MARK) begin
                    o.status = ST_NOT_IO;
                end else begin
                    clash = (node_family[r.node] != NO_MARK);
                    for (int i = r.node + 1; i < NODES; i++)
                        if (node_family[i] == k) clash = 1'b1;
                    if (clash) begin
                        o.status = ST_BAD_TABLE;
                    end else begin
                        node_family[r.node] = k;
                        node_base[r.node] = fam_total[k];
                        if (fam_members[k] == 0) begin
                            fam_first_node[k] = r.node;
                            fam_first_sites[k] = r.site_count;
                        end
                        fam_total[k] += r.site_count;
                        fam_members[k]++;
                        o.node_out = r.node;
                        o.value = node_base[r.node];
                    end
                end
            end
            OP_FWD: begin
                o.node_out = r.node;
                o.value = fake_on ? node_base[r.node] + r.index : r.index;
            end
            OP_REV: begin
                if (!fake_on) begin
                    o.node_out = r.io_node;
                    o.value = r.index;
                end else if (k == NO_MARK) begin
                    o.status = ST_NOT_IO;
                end else if (fam_members[k] == 0 ||
                             (fam_members[k] > 1 && fam_first_sites[k] == 0)) begin
                    o.status = ST_BAD_TABLE;
                end else begin
                    found = fam_first_node[k];
                    if (fam_members[k] > 1)
                        for (int i = 0; i < NODES; i++)
                            if (node_family[i] == k && node_base[i] <= r.index) found = i;
                    o.node_out = 8'(found);
                    o.value = r.index - node_base[found];
                end
            end
            OP_SITES: begin
                if (k == NO_MARK) o.status = ST_NOT_IO;
                else o.value = fam_total[k];
            end
            OP_RANK: begin
                if (!fake_on) o.value = 32'(r.io_node);
                else if (k == NO_MARK) begin
                    o.status = ST_NOT_IO;
                    o.value = ALL_ONES;
                end else o.value = 32'(k);
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic issue(logic [2:0] op, logic [7:0] node, logic [7:0] io,
                         logic [4:0] rank, logic [23:0] sites, logic [31:0] idx);
        request_t r;
        r = '{op, node, io, rank, sites, idx};
        word_q.push_back(r);
        answer_q.push_back(translate(r));
        if (op == OP_REG_IO) io_pool.push_back(io);
    endtask

    task automatic random_word();
        int         pick;
        logic [7:0] io;
        logic [5:0] k;
        logic [23:0] sites;
        longint     span;
        pick = $urandom_range(99);
        io = (io_pool.size() != 0 && $urandom_range(99) < 85) ?
             io_pool[$urandom_range(io_pool.size() - 1)] : 8'($urandom);
        k = io_rank[io];
        if (pick < 10) begin
            issue(OP_REG_IO, 8'($urandom), 8'($urandom), 5'($urandom), 24'($urandom),
                  $urandom);
        end else if (pick < 32) begin
            case ($urandom_range(9))
                0:       sites = 24'd0;
                1:       sites = 24'($urandom);
                default: sites = 24'($urandom_range(1, 64));
            endcase
            if (next_node < NODES && $urandom_range(99) < 85) begin
                issue(OP_ADD, 8'(next_node), io, 5'($urandom), sites, $urandom);
                next_node += $urandom_range(1, 3);
            end else begin
                issue(OP_ADD, 8'($urandom), io, 5'($urandom), sites, $urandom);
            end
        end else if (pick < 50) begin
            issue(OP_FWD, 8'($urandom), 8'($urandom), 5'($urandom), 24'($urandom),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(255));
        end else if (pick < 78) begin
            span = (k == NO_MARK) ? 64 : longint'(fam_total[k]) + 8;
            if (span > 32'hFFFF_FFFF) span = 32'hFFFF_FFFF;
            issue(OP_REV, 8'($urandom), io, 5'($urandom), 24'($urandom),
                  $urandom_range(4) == 0 ? $urandom : $urandom_range(32'(span)));
        end else if (pick < 86) begin
            issue(OP_SITES, 8'($urandom), io, 5'($urandom), 24'($urandom), $urandom);
        end else if (pick < 95) begin
            issue(OP_RANK, 8'($urandom), io, 5'($urandom), 24'($urandom), $urandom);
        end else begin
            issue(3'($urandom_range(6, 7)), 8'($urandom), 8'($urandom), 5'($urandom),
                  24'($urandom), $urandom);
        end
    endtask

    task automatic drain();
        while (word_q.size() != 0 || s_valid || answer_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_layout(logic v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        fake_on = v;
    endtask

    // driver: hold the word until taken, then advance or idle
    always @(posedge aclk) s_took <= s_valid && s_ready;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                drv_word = word_q.pop_front();
                s_valid <= 1'b1;
                s_op <= drv_word.op;
                s_node <= drv_word.node;
                s_io_node <= drv_word.io_node;
                s_rank <= drv_word.rank;
                s_site_count <= drv_word.site_count;
                s_index <= drv_word.index;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d node %0d value %h",
                             m_status, m_node_out, m_value);
            end else begin
                want = answer_q.pop_front();
                if (m_status !== want.status || m_node_out !== want.node_out ||
                    m_value !== want.value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%h got %0d/%0d/%h",
                                 want.status, want.node_out, want.value,
                                 m_status, m_node_out, m_value);
                end
            end
        end
    end

    initial begin
        fake_on = 1'b1;
        for (int i = 0; i < NODES; i++) begin
            io_rank[i] = NO_MARK;
            node_family[i] = NO_MARK;
            node_base[i] = '0;
        end
        for (int i = 0; i < FAMILIES; i++) begin
            fam_total[i] = '0;
            fam_members[i] = 0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_layout(1'b1);

        // directed: lookups on empty tables, ordering faults, bad families
        issue(OP_RANK,   8'd0,   8'd10,  5'd0,  24'd0, 32'd0);
        issue(OP_SITES,  8'd0,   8'd10,  5'd0,  24'd0, 32'd0);
        issue(OP_ADD,    8'd1,   8'd10,  5'd0,  24'd5, 32'd0);
        issue(OP_REV,    8'd0,   8'd10,  5'd0,  24'd0, 32'd3);
        issue(OP_REG_IO, 8'd0,   8'd10,  5'd3,  24'd0, 32'd0);
        issue(OP_REG_IO, 8'd0,   8'd255, 5'd31, 24'd0, 32'd0);
        issue(OP_REG_IO, 8'd0,   8'd0,   5'd0,  24'd0, 32'd0);
        issue(OP_REV,    8'd0,   8'd10,  5'd0,  24'd0, 32'd3);
        issue(OP_ADD,    8'd5,   8'd10,  5'd0,  24'd0, 32'd0);
        issue(OP_ADD,    8'd7,   8'd10,  5'd0,  24'd100, 32'd0);
        issue(OP_REV,    8'd0,   8'd10,  5'd0,  24'd0, 32'd50);
        issue(OP_ADD,    8'd5,   8'd10,  5'd0,  24'd1, 32'd0);
        issue(OP_ADD,    8'd2,   8'd10,  5'd0,  24'd1, 32'd0);
        issue(OP_ADD,    8'd20,  8'd255, 5'd0,  24'hFF_FFFF, 32'd0);
        issue(OP_ADD,    8'd30,  8'd255, 5'd0,  24'd1, 32'd0);
        issue(OP_REV,    8'd0,   8'd255, 5'd0,  24'd0, 32'h00FF_FFFF);
        issue(OP_REV,    8'd0,   8'd255, 5'd0,  24'd0, 32'h00FF_FFFE);
        issue(OP_REV,    8'd0,   8'd255, 5'd0,  24'd0, 32'hFFFF_FFFF);
        issue(OP_FWD,    8'd30,  8'd0,   5'd0,  24'd0, 32'hFFFF_FFFF);
        issue(OP_FWD,    8'd255, 8'd0,   5'd0,  24'd0, 32'h1234_5678);
        issue(OP_SITES,  8'd0,   8'd255, 5'd0,  24'd0, 32'd0);
        issue(OP_RANK,   8'd0,   8'd255, 5'd0,  24'd0, 32'd0);
        issue(OP_REG_IO, 8'd0,   8'd0,   5'd5,  24'd0, 32'd0);
        issue(3'd6,      8'd0,   8'd0,   5'd0,  24'd0, 32'd0);
        issue(3'd7,      8'hFF,  8'hFF,  5'h1F, 24'hFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_ADD,    8'd40,  8'd0,   5'd0,  24'd5, 32'd0);
        issue(OP_REV,    8'd0,   8'd0,   5'd0,  24'd0, 32'd2);
        next_node = 41;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 68; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 68; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            drain();
            write_layout(phase != 1);
            repeat (150) random_word();
        end
        send_idle = 0;
        recv_stall = 0;
        drain();

        if (mismatches == 0) begin
            $display("partition_index_translator_unit test passed");
        end else begin
            $display("partition_index_translator_unit test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/pit_pkg.sv
src/pit_front.sv
src/pit_queue.sv
src/pit_back.sv
src/partition_index_translator_unit.sv
src/pit_checker.sv
bench/partition_index_translator_unit_tb.sv
